// ===== hw/rtl/eht_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the key hash for the extendible hash table.
// No dependencies; every other file of the block imports this package.
package eht_pkg;

	localparam int DEF_MAX_DEPTH = 8;
	localparam int DEF_SLOTS = 4;

	localparam int ACT_W = 2;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int STAT_W = 2;

	localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_DUP  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	// Swap the halves of the key at a width that depends on its magnitude; keys below 16 pass unchanged.
	function automatic logic [KEY_W-1:0] hash_key(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] h;
		begin
			if (k[31:4] == 28'd0) begin
				h = k;
			end else if (k[31:8] == 24'd0) begin
				h = {24'd0, k[3:0], k[7:4]};
			end else if (k[31:16] == 16'd0) begin
				h = {16'd0, k[7:0], k[15:8]};
			end else begin
				h = {k[15:0], k[31:16]};
			end
			return h;
		end
	endfunction

endpackage

// ===== hw/rtl/eht_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses of the hash table.
// Depends on eht_pkg for the field widths.
interface eht_req_if import eht_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [KEY_W-1:0] key;
	logic [VAL_W-1:0] value;

	modport source (output valid, action, key, value, input ready);
	modport sink (input valid, action, key, value, output ready);
endinterface

interface eht_rsp_if import eht_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [VAL_W-1:0]  found_value;

	modport source (output valid, status, found_value, input ready);
	modport sink (input valid, status, found_value, output ready);
endinterface

// ===== hw/rtl/extendible_hash_table_unit.sv =====
`timescale 1ns / 1ps
// Top level of the extendible hash table: sequencer, memories and response register.
// Depends on eht_pkg and the channel interfaces in eht_if.sv.
//
// Usage: each beat on req carries an action (search, insert or delete), a key and,
// for inserts, a value. Exactly one beat leaves on rsp for every request: a status
// and, for a successful search, the stored value (zero otherwise).
// The block handles one request at a time. req.ready is high only while the
// sequencer is idle. A search, delete or simple insert goes from the request
// beat through a directory read, a bucket read and an evaluation state to the
// response register. An insert into a full bucket adds a split, in which the
// old bucket keeps the records that stay, the others move to a new bucket and
// the directory entries for the new bucket are rewritten; whenever the
// directory doubles, a read and write pass over every directory entry comes
// first. The lookup is repeated after each split.
// After reset a clearing pass writes the two initial directory entries and
// buckets; req.ready stays low during it.
// The response register frees the sequencer from the receiver: a new request
// is taken while a response waits. If rsp is stalled when the next response is
// ready, the sequencer holds in its evaluation cycle until the register frees.
module extendible_hash_table_unit import eht_pkg::*; #(
	parameter int MAX_DEPTH = DEF_MAX_DEPTH,
	parameter int SLOTS = DEF_SLOTS
) (
	input logic        clk,
	input logic        arst_n,
	eht_req_if.sink    req,
	eht_rsp_if.source  rsp
);

	localparam int DIR_N = 1 << MAX_DEPTH;
	localparam int IW = MAX_DEPTH;
	localparam int GW = $clog2(MAX_DEPTH + 1);
	localparam int SW = $clog2(SLOTS);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD_DIR, S_RD_BKT, S_EVAL,
		S_DBL_RD, S_DBL_WR, S_SPL_A, S_SPL_B, S_SPL_DIR
	} state_t;

	typedef logic [SLOTS-1:0][KEY_W-1:0] key_row_t;
	typedef logic [SLOTS-1:0][VAL_W-1:0] val_row_t;

	// Memories: directory, per-bucket depth, occupancy mask, key and payload rows.
	logic [IW-1:0] dir_mem [DIR_N];
	logic [GW-1:0] bdep_mem [DIR_N];
	logic [SLOTS-1:0] used_mem [DIR_N];
	key_row_t key_mem [DIR_N];
	val_row_t pay_mem [DIR_N];

	logic [IW-1:0] dir_rd_q;
	logic [GW-1:0] bdep_rd_q;
	logic [SLOTS-1:0] used_rd_q;
	key_row_t key_rd_q;
	val_row_t pay_rd_q;

	state_t st_q;
	logic clr_q;
	logic [GW-1:0] gd_q;
	logic [IW:0] biu_q;
	logic [ACT_W-1:0] act_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [IW-1:0] bkt_q;
	logic [IW-1:0] nb_q;
	logic [IW-1:0] k_q;
	logic [IW-1:0] start_q;
	logic [IW-1:0] span_q;
	logic [IW-1:0] cnt_q;

	logic ovalid_q;
	status_t ostat_q;
	logic [VAL_W-1:0] ofv_q;

	function automatic logic [IW-1:0] dir_idx(input logic [KEY_W-1:0] h,
			input logic [GW-1:0] g);
		logic [IW-1:0] rev;
		begin
			for (int i = 0; i < IW; i++) begin
				rev[i] = h[IW-1-i];
			end
			return rev >> (GW'(IW) - g);
		end
	endfunction

	// Combinational view of the bucket row that was just read.
	logic [KEY_W-1:0] hash_q;
	logic [IW-1:0] loc;
	logic [SLOTS-1:0] hit_v;
	logic hit;
	logic [SW-1:0] hit_s;
	logic has_free;
	logic [SW-1:0] free_s;
	logic [GW-1:0] new_d;
	logic [SLOTS-1:0] mv;
	logic [SLOTS-1:0] pk_used;
	key_row_t pk_key;
	val_row_t pk_pay;
	logic [IW-1:0] span_c;
	logic [IW:0] span2m1;
	logic [IW-1:0] start_c;
	logic out_free;

	assign hash_q = hash_key(key_q);
	assign loc = dir_idx(hash_q, gd_q);
	assign new_d = bdep_rd_q + 1'b1;
	assign span_c = IW'(1) << (gd_q - new_d);
	assign span2m1 = {span_c - 1'b1, 1'b1};
	assign start_c = (loc & ~span2m1[IW-1:0]) + span_c;
	assign out_free = !ovalid_q || rsp.ready;

	always_comb begin
		logic [SW:0] n;
		logic [KEY_W-1:0] hk;
		n = '0;
		hit_s = '0;
		free_s = '0;
		pk_used = '0;
		pk_key = key_rd_q;
		pk_pay = pay_rd_q;
		for (int s = 0; s < SLOTS; s++) begin
			hit_v[s] = used_rd_q[s] && (key_rd_q[s] == key_q);
			hk = hash_key(key_rd_q[s]);
			mv[s] = used_rd_q[s] && hk[new_d - 1'b1];
		end
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (hit_v[s]) begin
				hit_s = SW'(s);
			end
			if (!used_rd_q[s]) begin
				free_s = SW'(s);
			end
		end
		// Records that move are packed into the new bucket in ascending slot order.
		for (int s = 0; s < SLOTS; s++) begin
			if (mv[s]) begin
				pk_key[n[SW-1:0]] = key_rd_q[s];
				pk_pay[n[SW-1:0]] = pay_rd_q[s];
				pk_used[n[SW-1:0]] = 1'b1;
				n = n + 1'b1;
			end
		end
	end

	assign hit = |hit_v;
	assign has_free = ~&used_rd_q;

	// Memory port control.
	logic dir_re, bkt_re;
	logic [IW-1:0] dir_ra, bkt_ra;
	logic dir_we, bdep_we, used_we, row_we;
	logic [IW-1:0] dir_wa, bdep_wa, used_wa, row_wa;
	logic [IW-1:0] dir_wd;
	logic [GW-1:0] bdep_wd;
	logic [SLOTS-1:0] used_wd;
	key_row_t key_wd;
	val_row_t pay_wd;

	always_comb begin
		dir_re = 1'b0;
		dir_ra = loc;
		bkt_re = 1'b0;
		bkt_ra = dir_rd_q;
		dir_we = 1'b0;
		dir_wa = k_q;
		dir_wd = dir_rd_q;
		bdep_we = 1'b0;
		bdep_wa = bkt_q;
		bdep_wd = new_d;
		used_we = 1'b0;
		used_wa = bkt_q;
		used_wd = used_rd_q;
		row_we = 1'b0;
		row_wa = bkt_q;
		key_wd = key_rd_q;
		pay_wd = pay_rd_q;
		unique case (st_q)
			S_CLR: begin
				dir_we = 1'b1;
				dir_wa = IW'(clr_q);
				dir_wd = IW'(clr_q);
				bdep_we = 1'b1;
				bdep_wa = IW'(clr_q);
				bdep_wd = GW'(1);
				used_we = 1'b1;
				used_wa = IW'(clr_q);
				used_wd = '0;
			end
			S_RD_DIR: begin
				dir_re = 1'b1;
			end
			S_RD_BKT: begin
				bkt_re = 1'b1;
			end
			S_EVAL: begin
				if (out_free && act_q == ACT_DELETE && hit) begin
					used_we = 1'b1;
					used_wd[hit_s] = 1'b0;
				end
				if (out_free && act_q == ACT_INSERT && !hit && has_free) begin
					used_we = 1'b1;
					used_wd[free_s] = 1'b1;
					row_we = 1'b1;
					key_wd[free_s] = key_q;
					pay_wd[free_s] = val_q;
				end
			end
			S_DBL_RD: begin
				dir_re = 1'b1;
				dir_ra = k_q >> 1;
			end
			S_DBL_WR: begin
				dir_we = 1'b1;
			end
			S_SPL_A: begin
				bdep_we = 1'b1;
				used_we = 1'b1;
				used_wd = used_rd_q & ~mv;
			end
			S_SPL_B: begin
				bdep_we = 1'b1;
				bdep_wa = nb_q;
				used_we = 1'b1;
				used_wa = nb_q;
				used_wd = pk_used;
				row_we = 1'b1;
				row_wa = nb_q;
				key_wd = pk_key;
				pay_wd = pk_pay;
			end
			S_SPL_DIR: begin
				dir_we = 1'b1;
				dir_wa = start_q + cnt_q;
				dir_wd = nb_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_wa] <= dir_wd;
		end
		if (dir_re) begin
			dir_rd_q <= dir_mem[dir_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (bdep_we) begin
			bdep_mem[bdep_wa] <= bdep_wd;
		end
		if (bkt_re) begin
			bdep_rd_q <= bdep_mem[bkt_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (used_we) begin
			used_mem[used_wa] <= used_wd;
		end
		if (bkt_re) begin
			used_rd_q <= used_mem[bkt_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			key_mem[row_wa] <= key_wd;
			pay_mem[row_wa] <= pay_wd;
		end
		if (bkt_re) begin
			key_rd_q <= key_mem[bkt_ra];
			pay_rd_q <= pay_mem[bkt_ra];
		end
	end

	assign req.ready = (st_q == S_IDLE);
	assign rsp.valid = ovalid_q;
	assign rsp.status = ostat_q;
	assign rsp.found_value = ofv_q;

	// Sequencer and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			clr_q <= 1'b0;
			gd_q <= GW'(1);
			biu_q <= (IW+1)'(2);
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && rsp.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (st_q)
				S_CLR: begin
					clr_q <= 1'b1;
					if (clr_q) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						act_q <= req.action;
						key_q <= req.key;
						val_q <= req.value;
						st_q <= S_RD_DIR;
					end
				end
				S_RD_DIR: begin
					st_q <= S_RD_BKT;
				end
				S_RD_BKT: begin
					bkt_q <= dir_rd_q;
					st_q <= S_EVAL;
				end
				S_EVAL: begin
					if (out_free) begin
						ofv_q <= '0;
						ostat_q <= ST_MISS;
						st_q <= S_IDLE;
						ovalid_q <= 1'b1;
						unique case (act_q)
							ACT_SEARCH: begin
								if (hit) begin
									ostat_q <= ST_OK;
									ofv_q <= pay_rd_q[hit_s];
								end
							end
							ACT_DELETE: begin
								if (hit) begin
									ostat_q <= ST_OK;
								end
							end
							ACT_INSERT: begin
								if (hit) begin
									ostat_q <= ST_DUP;
								end else if (has_free) begin
									ostat_q <= ST_OK;
								end else if (bdep_rd_q >= gd_q) begin
									if (gd_q >= GW'(MAX_DEPTH)) begin
										ostat_q <= ST_FULL;
									end else begin
										ovalid_q <= ovalid_q && !rsp.ready;
										k_q <= IW'((32'd1 << (gd_q + 1'b1)) - 32'd1);
										st_q <= S_DBL_RD;
									end
								end else begin
									ovalid_q <= ovalid_q && !rsp.ready;
									st_q <= S_SPL_A;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DBL_RD: begin
					st_q <= S_DBL_WR;
				end
				S_DBL_WR: begin
					if (k_q == '0) begin
						gd_q <= gd_q + 1'b1;
						st_q <= S_SPL_A;
					end else begin
						k_q <= k_q - 1'b1;
						st_q <= S_DBL_RD;
					end
				end
				S_SPL_A: begin
					nb_q <= biu_q[IW-1:0];
					biu_q <= biu_q + 1'b1;
					start_q <= start_c;
					span_q <= span_c;
					st_q <= S_SPL_B;
				end
				S_SPL_B: begin
					cnt_q <= '0;
					st_q <= S_SPL_DIR;
				end
				S_SPL_DIR: begin
					if (cnt_q == span_q - 1'b1) begin
						st_q <= S_RD_DIR;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	a_gd_range: assert property (@(posedge clk) disable iff (!arst_n)
		gd_q >= GW'(1) && gd_q <= GW'(MAX_DEPTH))
		else $error("global depth out of range");

	a_gd_step: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DBL_WR && k_q == '0) |=> gd_q == $past(gd_q) + 1'b1)
		else $error("directory doubling did not raise global depth");

	a_biu_bound: assert property (@(posedge clk) disable iff (!arst_n)
		biu_q <= (IW+1)'(DIR_N))
		else $error("more buckets than directory entries");

	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(st_q == S_EVAL))
		else $error("response raised outside evaluation");

endmodule
